@@ sv/dssc_pkg.sv @@
`default_nettype none
package dssc_pkg;
  localparam int REGIONS = 16;
  localparam int SLOT_W = $clog2(REGIONS);
  localparam int CNT_W = $clog2(REGIONS + 1);
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    ACT_LOAD  = 3'd0,
    ACT_DSEEK = 3'd1,
    ACT_ASEEK = 3'd2,
    ACT_BEGIN = 3'd3,
    ACT_END   = 3'd4
  } action_t;

  localparam logic [0:0] CFG_DISC_TYPE = 1'b0;
  localparam logic [0:0] CFG_REGION_COUNT = 1'b1;
  localparam logic [7:0] DISC_XA = 8'h20;
  localparam logic [7:0] AUDIO_MODE = 8'h12;
  localparam logic [10:0] SECTOR_WORDS = 11'd1176;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  region_slot;
    logic [23:0] region_first_sector;
    logic [7:0]  region_kind;
    logic [31:0] region_block_base;
    logic [23:0] sector;
    logic [7:0]  read_mode;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] file_block;
    logic [7:0]  found_kind;
    logic [7:0]  offset_words;
    logic [8:0]  length_words;
    logic        discard_buffer;
    logic        fetch_buffer;
    logic        sector_done;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } seek_state_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  lead;
    logic [7:0]  trail;
  } mode_dec_t;

  function automatic mode_dec_t decode_mode(input logic [7:0] mode, input logic [7:0] kind,
                                            input logic xa);
    mode_dec_t r;
    logic dt;
    logic [7:0] b;
    logic [7:0] a;
    logic good;
    dt = kind[2];
    b = 8'd0;
    a = 8'd0;
    good = 1'b1;
    unique case (mode[3:1])
      3'd0: begin
        if (!mode[4]) begin
          if (!dt) good = 1'b0;
          else if (xa) begin
            a = 8'd140;
            if (!mode[6]) b = 8'd4;
          end else a = 8'd144;
        end
      end
      3'd1: if (dt) good = 1'b0;
      3'd2, 3'd3: begin
        if (mode[3:1] == 3'd2) a = 8'd144;
        if (!dt || xa) good = 1'b0;
      end
      3'd4, 3'd5: begin
        a = (mode[3:1] == 3'd4) ? 8'd140 : 8'd2;
        if (!dt || !xa) good = 1'b0;
        if (!mode[6]) b = 8'd4;
      end
      3'd6: ;
      default: good = 1'b0;
    endcase
    if (mode[4]) begin
      b = 8'd0;
      a = 8'd0;
    end else if (!mode[5]) good = 1'b0;
    else if (!mode[7]) b = b + 8'd8;
    r.ok = good;
    r.lead = b;
    r.trail = a;
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/dssc_if.sv @@
`default_nettype none
interface dssc_in_if;
  logic valid;
  logic ready;
  dssc_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface dssc_out_if;
  logic valid;
  logic ready;
  dssc_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface dssc_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [7:0] wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ sv/dssc_queue.sv @@
`default_nettype none
module dssc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire dssc_pkg::in_item_t   push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      empty,
  output dssc_pkg::in_item_t        pop_data
);
  localparam int AW = $clog2(dssc_pkg::QDEPTH);
  dssc_pkg::in_item_t mem [dssc_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full = (cnt_r == (AW+1)'(dssc_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign pop_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) full |=> cnt_r <= (AW+1)'(dssc_pkg::QDEPTH);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && !empty)) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count");
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    empty |=> cnt_r <= 1) else $error("queue empty pop");
endmodule
`default_nettype wire

@@ sv/dssc_back.sv @@
`default_nettype none
module dssc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire dssc_pkg::in_item_t q_data,
  output logic                    q_pop,
  input  wire logic [7:0]         disc_type,
  input  wire logic [dssc_pkg::CNT_W-1:0] region_count,
  dssc_out_if.source              out_ch
);
  dssc_pkg::seek_state_t st_r, st_nxt;
  logic [23:0] start_mem [dssc_pkg::REGIONS];
  logic [7:0]  kind_mem [dssc_pkg::REGIONS];
  logic [31:0] base_mem [dssc_pkg::REGIONS];

  logic [dssc_pkg::CNT_W-1:0] idx_r, idx_nxt, cnt;
  logic [23:0] rd_start_r;
  logic [7:0]  rd_kind_r;
  logic [31:0] rd_base_r;
  logic        found_r, found_nxt;
  logic [7:0]  fkind_r, fkind_nxt;
  logic [31:0] blk_r, blk_nxt;
  logic [7:0]  offs_r, offs_nxt;
  logic [23:0] diff;
  logic [31:0] raw;

  logic [7:0]  boff_r, boff_nxt;
  logic [3:0]  shead_r, shead_nxt;
  logic [7:0]  stail_r, stail_nxt;
  logic [10:0] pay_r, pay_nxt;
  logic [10:0] done_r, done_nxt;
  logic        stale_r, stale_nxt;
  logic [8:0]  clen_r, clen_nxt;

  logic        ov_r, ov_nxt;
  dssc_pkg::out_item_t o_r, o_nxt;
  dssc_pkg::mode_dec_t md;
  logic [7:0]  mode;
  logic [10:0] rem, wd;
  logic [8:0]  room;
  logic [7:0]  bo;
  logic        stl;
  logic        can_out;

  assign cnt = (region_count > dssc_pkg::CNT_W'(dssc_pkg::REGIONS))
             ? dssc_pkg::CNT_W'(dssc_pkg::REGIONS) : region_count;
  assign diff = q_data.sector - rd_start_r;
  assign raw = 32'(diff) * 32'd147;
  assign mode = (q_data.action == dssc_pkg::ACT_DSEEK) ? q_data.read_mode
                                                       : dssc_pkg::AUDIO_MODE;
  assign md = dssc_pkg::decode_mode(mode, fkind_r, disc_type == dssc_pkg::DISC_XA);
  assign can_out = !ov_r || out_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data = o_r;

  always_ff @(posedge clk) begin
    if (!q_empty && can_out && st_r == dssc_pkg::ST_IDLE &&
        q_data.action == dssc_pkg::ACT_LOAD) begin
      start_mem[q_data.region_slot[dssc_pkg::SLOT_W-1:0]] <= q_data.region_first_sector;
      kind_mem[q_data.region_slot[dssc_pkg::SLOT_W-1:0]] <= q_data.region_kind;
      base_mem[q_data.region_slot[dssc_pkg::SLOT_W-1:0]] <= q_data.region_block_base;
    end
  end

  // table entry for the next scan index
  always_ff @(posedge clk) begin
    rd_start_r <= start_mem[idx_nxt[dssc_pkg::SLOT_W-1:0]];
    rd_kind_r <= kind_mem[idx_nxt[dssc_pkg::SLOT_W-1:0]];
    rd_base_r <= base_mem[idx_nxt[dssc_pkg::SLOT_W-1:0]];
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    fkind_nxt = fkind_r;
    blk_nxt = blk_r;
    offs_nxt = offs_r;
    boff_nxt = boff_r;
    shead_nxt = shead_r;
    stail_nxt = stail_r;
    pay_nxt = pay_r;
    done_nxt = done_r;
    stale_nxt = stale_r;
    clen_nxt = clen_r;
    ov_nxt = ov_r && !out_ch.ready;
    o_nxt = o_r;
    q_pop = 1'b0;
    rem = '0;
    room = '0;
    wd = '0;
    bo = boff_r;
    stl = stale_r;
    unique case (st_r)
      dssc_pkg::ST_IDLE: begin
        if (!q_empty && can_out) begin
          o_nxt = '0;
          o_nxt.ok = 1'b1;
          if (q_data.action == dssc_pkg::ACT_DSEEK ||
              q_data.action == dssc_pkg::ACT_ASEEK) begin
            st_nxt = dssc_pkg::ST_SCAN;
            idx_nxt = '0;
            found_nxt = 1'b0;
            fkind_nxt = 8'hff;
            blk_nxt = '0;
            offs_nxt = '0;
          end else begin
            q_pop = 1'b1;
            ov_nxt = 1'b1;
            if (q_data.action == dssc_pkg::ACT_BEGIN) begin
              if (done_r == '0) begin
                if (9'(shead_r) > 9'd255 - 9'(bo)) begin
                  if (stl) o_nxt.discard_buffer = 1'b1;
                  stl = 1'b1;
                end
                bo = bo + 8'(shead_r);
              end
              if (stl) begin
                o_nxt.fetch_buffer = 1'b1;
                stl = 1'b0;
              end
              rem = (done_r < pay_r) ? pay_r - done_r : '0;
              room = 9'd256 - 9'(bo);
              clen_nxt = (11'(room) < rem) ? room : 9'(rem);
              o_nxt.offset_words = bo;
              o_nxt.length_words = clen_nxt;
              boff_nxt = bo;
              stale_nxt = stl;
            end else if (q_data.action == dssc_pkg::ACT_END) begin
              wd = done_r + 11'(clen_r);
              bo = boff_r + clen_r[7:0];
              if (bo == '0) stl = 1'b1;
              o_nxt.length_words = clen_r;
              if (wd >= pay_r) begin
                wd = '0;
                if (stail_r > 8'd255 - bo) begin
                  if (stl) o_nxt.discard_buffer = 1'b1;
                  stl = 1'b1;
                end
                bo = bo + stail_r;
                o_nxt.sector_done = 1'b1;
              end
              o_nxt.offset_words = bo;
              done_nxt = wd;
              boff_nxt = bo;
              stale_nxt = stl;
            end
          end
        end
      end
      dssc_pkg::ST_SCAN: begin
        if (idx_r < cnt && q_data.sector >= rd_start_r) begin
          found_nxt = 1'b1;
          fkind_nxt = rd_kind_r;
          offs_nxt = {raw[4:0], 3'b000};
          blk_nxt = {5'd0, raw[31:5]} + rd_base_r;
          idx_nxt = idx_r + 1'b1;
        end else st_nxt = dssc_pkg::ST_DONE;
      end
      dssc_pkg::ST_DONE: begin
        q_pop = 1'b1;
        ov_nxt = 1'b1;
        st_nxt = dssc_pkg::ST_IDLE;
        o_nxt.file_block = blk_r;
        o_nxt.found_kind = fkind_r;
        o_nxt.offset_words = offs_r;
        o_nxt.ok = found_r && md.ok;
        if (found_r && md.ok && q_data.action == dssc_pkg::ACT_DSEEK) begin
          pay_nxt = dssc_pkg::SECTOR_WORDS - 11'(md.lead) - 11'(md.trail);
          boff_nxt = offs_r;
          shead_nxt = md.lead[3:0];
          stail_nxt = md.trail;
          stale_nxt = 1'b1;
          done_nxt = '0;
        end
      end
      default: st_nxt = dssc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dssc_pkg::ST_IDLE;
      ov_r <= 1'b0;
      boff_r <= '0;
      shead_r <= '0;
      stail_r <= '0;
      pay_r <= '0;
      done_r <= '0;
      stale_r <= 1'b0;
      clen_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      boff_r <= boff_nxt;
      shead_r <= shead_nxt;
      stail_r <= stail_nxt;
      pay_r <= pay_nxt;
      done_r <= done_nxt;
      stale_r <= stale_nxt;
      clen_r <= clen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    found_r <= found_nxt;
    fkind_r <= fkind_nxt;
    blk_r <= blk_nxt;
    offs_r <= offs_nxt;
    o_r <= o_nxt;
  end

  a_scan_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == dssc_pkg::ST_DONE |-> can_out) else $error("seek finish without room");
  a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> ov_r) else $error("popped item without result");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == dssc_pkg::ST_SCAN |-> idx_r <= cnt) else $error("scan past count");
  a_chunk_len: assert property (@(posedge clk) disable iff (!rst_n)
    clen_r <= 9'd256) else $error("chunk length");
endmodule
`default_nettype wire

@@ sv/disc_sector_seek_and_chunker.sv @@
// Disc sector seek and transfer chunker.
// Channels: in_ (action and payload), out_ (one result per accepted item),
// cfg_ (register write: index 0 disc_type, 1 region_count; always ready).
// A transaction completes where valid and ready are both high.
// The front accepts items into a two-entry queue; the back executes them.
// Load, begin chunk and end chunk are executed directly by the back; a seek scans the
// region table one entry per cycle, over at most region_count entries, capped at 16.
// The output register holds a result while out_ready is low; the back then
// stalls and the queue fills, after which in_ready drops.
// Reset (rst_n low, synchronous) clears the chunk state, registers and
// queue; the region table is undefined until loaded.
`default_nettype none
module disc_sector_seek_and_chunker (
  input  wire logic clk,
  input  wire logic rst_n,
  dssc_in_if.sink   in_ch,
  dssc_out_if.source out_ch,
  dssc_cfg_if.sink  cfg_ch
);
  logic [7:0] disc_type_r;
  logic [4:0] region_count_r;
  logic q_full, q_empty, q_pop;
  dssc_pkg::in_item_t q_data;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_type_r <= '0;
      region_count_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dssc_pkg::CFG_DISC_TYPE: disc_type_r <= cfg_ch.wdata;
        dssc_pkg::CFG_REGION_COUNT: region_count_r <= cfg_ch.wdata[4:0];
        default: ;
      endcase
    end
  end

  dssc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_ch.valid), .push_data(in_ch.data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_data)
  );

  dssc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .disc_type(disc_type_r), .region_count(region_count_r),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire

@@ dv/dssc_tb_if.sv @@
`timescale 1ns / 1ps
package dssc_tb_util;
  function automatic dssc_pkg::in_item_t blank_item();
    dssc_pkg::in_item_t it;
    it = '0;
    return it;
  endfunction
endpackage

@@ dv/disc_sector_seek_and_chunker_tb.sv @@
`timescale 1ns / 1ps
module disc_sector_seek_and_chunker_tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dssc_in_if in_ch();
  dssc_out_if out_ch();
  dssc_cfg_if cfg_ch();

  disc_sector_seek_and_chunker uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [23:0] mdl_start [dssc_pkg::REGIONS];
  logic [7:0]  mdl_kind [dssc_pkg::REGIONS];
  logic [31:0] mdl_base [dssc_pkg::REGIONS];
  logic [7:0]  mdl_disc_type;
  logic [4:0]  mdl_count;
  logic [7:0]  mdl_offset;
  logic [7:0]  mdl_skip_head;
  logic [7:0]  mdl_skip_tail;
  logic [10:0] mdl_payload;
  logic [10:0] mdl_done_words;
  logic        mdl_stale;
  logic [8:0]  mdl_chunk_len;

  dssc_pkg::out_item_t pending_results[$];
  int errors = 0;
  int rx_cycle = 0;
  bit burst_on = 1'b1;
  int burst_left = 8;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic bit mode_valid(input logic [7:0] mode, input logic [7:0] kind,
                                    output logic [7:0] b, output logic [7:0] a);
    bit dt, xa;
    dt = kind[2];
    xa = (mdl_disc_type == dssc_pkg::DISC_XA);
    b = 0;
    a = 0;
    case (mode[3:1])
      3'd0: if (!mode[4]) begin
        if (!dt) return 0;
        if (xa) begin
          a = 140;
          if (!mode[6]) b = 4;
        end else a = 144;
      end
      3'd1: if (dt) return 0;
      3'd2, 3'd3: begin
        if (mode[3:1] == 3'd2) a = 144;
        if (!dt || xa) return 0;
      end
      3'd4, 3'd5: begin
        a = (mode[3:1] == 3'd4) ? 8'd140 : 8'd2;
        if (!dt || !xa) return 0;
        if (!mode[6]) b = 4;
      end
      3'd6: ;
      default: return 0;
    endcase
    if (mode[4]) begin
      b = 0;
      a = 0;
    end else if (!mode[5]) return 0;
    else if (!mode[7]) b = b + 8;
    return 1;
  endfunction

  function automatic dssc_pkg::out_item_t predict_result(input dssc_pkg::in_item_t it);
    dssc_pkg::out_item_t r;
    int n;
    bit found;
    logic [31:0] raw;
    logic [7:0] b, a;
    logic [10:0] rem;
    logic [8:0] room;
    r = '0;
    r.ok = 1'b1;
    case (it.action)
      dssc_pkg::ACT_LOAD: begin
        mdl_start[it.region_slot] = it.region_first_sector;
        mdl_kind[it.region_slot] = it.region_kind;
        mdl_base[it.region_slot] = it.region_block_base;
      end
      dssc_pkg::ACT_DSEEK, dssc_pkg::ACT_ASEEK: begin
        n = (mdl_count > dssc_pkg::REGIONS) ? dssc_pkg::REGIONS : mdl_count;
        found = 0;
        r.found_kind = 8'hff;
        for (int i = 0; i < n; i++) begin
          if (it.sector >= mdl_start[i]) begin
            raw = (32'(it.sector) - 32'(mdl_start[i])) * 32'd147;
            found = 1;
            r.found_kind = mdl_kind[i];
            r.offset_words = {raw[4:0], 3'b000};
            r.file_block = (raw >> 5) + mdl_base[i];
          end else break;
        end
        r.ok = found && mode_valid(it.action == dssc_pkg::ACT_ASEEK ? dssc_pkg::AUDIO_MODE
                                                                    : it.read_mode,
                                   r.found_kind, b, a);
        if (r.ok && it.action == dssc_pkg::ACT_DSEEK) begin
          mdl_payload = dssc_pkg::SECTOR_WORDS - b - a;
          mdl_offset = r.offset_words;
          mdl_skip_head = b;
          mdl_skip_tail = a;
          mdl_stale = 1;
          mdl_done_words = 0;
        end
      end
      dssc_pkg::ACT_BEGIN: begin
        if (mdl_done_words == 0) begin
          if (mdl_skip_head > 8'd255 - mdl_offset) begin
            if (mdl_stale) r.discard_buffer = 1;
            mdl_stale = 1;
          end
          mdl_offset = mdl_offset + mdl_skip_head;
        end
        if (mdl_stale) begin
          r.fetch_buffer = 1;
          mdl_stale = 0;
        end
        rem = (mdl_done_words < mdl_payload) ? mdl_payload - mdl_done_words : 11'd0;
        room = 9'd256 - mdl_offset;
        mdl_chunk_len = (11'(room) < rem) ? room : 9'(rem);
        r.offset_words = mdl_offset;
        r.length_words = mdl_chunk_len;
      end
      dssc_pkg::ACT_END: begin
        mdl_done_words = mdl_done_words + mdl_chunk_len;
        mdl_offset = mdl_offset + 8'(mdl_chunk_len);
        if (mdl_offset == 0) mdl_stale = 1;
        r.length_words = mdl_chunk_len;
        if (mdl_done_words >= mdl_payload) begin
          mdl_done_words = 0;
          if (mdl_skip_tail > 8'd255 - mdl_offset) begin
            if (mdl_stale) r.discard_buffer = 1;
            mdl_stale = 1;
          end
          mdl_offset = mdl_offset + mdl_skip_tail;
          r.sector_done = 1;
        end
        r.offset_words = mdl_offset;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input dssc_pkg::in_item_t it);
    if (!burst_on || burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
      burst_on = 1;
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(predict_result(it));
    burst_left--;
    if ($urandom_range(0, 3) == 0) burst_on = 0;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == dssc_pkg::CFG_DISC_TYPE) mdl_disc_type = val;
    else mdl_count = val[4:0];
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    rx_cycle++;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (rx_cycle % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    dssc_pkg::out_item_t exp_r, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) report("unexpected result", 0, 0);
      else begin
        exp_r = pending_results.pop_front();
        if (got.ok !== exp_r.ok) report("ok", got.ok, exp_r.ok);
        if (got.file_block !== exp_r.file_block)
          report("file_block", got.file_block, exp_r.file_block);
        if (got.found_kind !== exp_r.found_kind)
          report("found_kind", got.found_kind, exp_r.found_kind);
        if (got.offset_words !== exp_r.offset_words)
          report("offset_words", got.offset_words, exp_r.offset_words);
        if (got.length_words !== exp_r.length_words)
          report("length_words", got.length_words, exp_r.length_words);
        if (got.discard_buffer !== exp_r.discard_buffer)
          report("discard_buffer", got.discard_buffer, exp_r.discard_buffer);
        if (got.fetch_buffer !== exp_r.fetch_buffer)
          report("fetch_buffer", got.fetch_buffer, exp_r.fetch_buffer);
        if (got.sector_done !== exp_r.sector_done)
          report("sector_done", got.sector_done, exp_r.sector_done);
      end
    end
  end

  function automatic dssc_pkg::in_item_t load_item(input logic [3:0] slot,
                                                   input logic [23:0] first,
                                                   input logic [7:0] kind,
                                                   input logic [31:0] base);
    dssc_pkg::in_item_t it;
    it = dssc_tb_util::blank_item();
    it.action = dssc_pkg::ACT_LOAD;
    it.region_slot = slot;
    it.region_first_sector = first;
    it.region_kind = kind;
    it.region_block_base = base;
    return it;
  endfunction

  function automatic dssc_pkg::in_item_t seek_item(input logic [2:0] act,
                                                   input logic [23:0] sec,
                                                   input logic [7:0] mode);
    dssc_pkg::in_item_t it;
    it = dssc_tb_util::blank_item();
    it.action = act;
    it.sector = sec;
    it.read_mode = mode;
    it.region_slot = 4'($urandom);
    it.region_first_sector = 24'($urandom);
    it.region_kind = 8'($urandom);
    it.region_block_base = $urandom;
    return it;
  endfunction

  // sorted random table over all 16 slots
  task automatic load_table(input bit wide);
    logic [23:0] s;
    s = wide ? 24'($urandom_range(0, 3)) : 24'($urandom_range(0, 50));
    for (int i = 0; i < dssc_pkg::REGIONS; i++) begin
      send_item(load_item(4'(i), s, 8'($urandom), $urandom));
      s = s + (wide ? 24'($urandom_range(1, 1000000)) : 24'($urandom_range(1, 40)));
    end
  endtask

  task automatic run_sector(input logic [23:0] sec, input logic [7:0] mode);
    send_item(seek_item(dssc_pkg::ACT_DSEEK, sec, mode));
    for (int k = 0; k < 8 && mdl_chunk_len != 0 || k < 2; k++) begin
      send_item(seek_item(dssc_pkg::ACT_BEGIN, 0, 0));
      send_item(seek_item(dssc_pkg::ACT_END, 0, 0));
    end
  endtask

  task automatic test_directed();
    write_reg(dssc_pkg::CFG_DISC_TYPE, 8'h00);
    write_reg(dssc_pkg::CFG_REGION_COUNT, 8'd0);
    send_item(seek_item(dssc_pkg::ACT_DSEEK, 24'd5, 8'h30));
    send_item(seek_item(dssc_pkg::ACT_BEGIN, 0, 0));
    send_item(seek_item(dssc_pkg::ACT_END, 0, 0));
    send_item(load_item(4'd0, 24'd10, 8'h04, 32'hffff_fff0));
    send_item(load_item(4'd1, 24'd20, 8'h00, 32'h0000_0100));
    send_item(load_item(4'd15, 24'hff_ffff, 8'hff, 32'hffff_ffff));
    for (int i = 2; i < 15; i++) send_item(load_item(4'(i), 24'(20 + i * 100), 8'h84, 32'(i)));
    write_reg(dssc_pkg::CFG_REGION_COUNT, 8'd16);
    send_item(seek_item(dssc_pkg::ACT_DSEEK, 24'd3, 8'h30));
    send_item(seek_item(dssc_pkg::ACT_DSEEK, 24'hff_ffff, 8'hff));
    send_item(seek_item(dssc_pkg::ACT_ASEEK, 24'd25, 8'h00));
    send_item(seek_item(dssc_pkg::ACT_ASEEK, 24'd12, 8'h00));
    send_item(seek_item(3'd5, 0, 0));
    send_item(seek_item(3'd7, 0, 0));
    run_sector(24'd13, 8'h20);
    write_reg(dssc_pkg::CFG_REGION_COUNT, 8'd31);
    write_reg(dssc_pkg::CFG_DISC_TYPE, dssc_pkg::DISC_XA);
    run_sector(24'd11, 8'h28);
    write_reg(dssc_pkg::CFG_DISC_TYPE, 8'hff);
  endtask

  task automatic test_random();
    dssc_pkg::in_item_t it;
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      write_reg(dssc_pkg::CFG_DISC_TYPE, ($urandom_range(0, 1)) ? dssc_pkg::DISC_XA
                                                                : 8'($urandom));
      write_reg(dssc_pkg::CFG_REGION_COUNT, 8'($urandom_range(0, 31)));
      load_table(phase[0]);
      for (int n = 0; n < 18; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            it = seek_item(3'($urandom_range(0, 7)), 24'($urandom), 8'($urandom));
            if (it.action == dssc_pkg::ACT_LOAD) it.action = dssc_pkg::ACT_BEGIN;
            send_item(it);
          end
          1: send_item(seek_item(dssc_pkg::ACT_ASEEK, 24'($urandom), 0));
          default: run_sector(phase[0] ? 24'($urandom) : 24'($urandom_range(0, 800)),
                              8'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("disc_sector_seek_and_chunker regression: pass");
    else $display("disc_sector_seek_and_chunker regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("disc_sector_seek_and_chunker regression: fail");
    $finish;
  end
endmodule
